>>> hdl/tvd_pkg.sv
// Shared types, constants and lookup tables for the TV divergence unit.
// Used by tvd_controller, tvd_datapath and the top level; no dependencies.
`timescale 1ns / 1ps
package tvd_pkg;

  localparam int SZ_W       = 7;
  localparam int INV_W      = 32;
  localparam int DATA_W     = 32;
  localparam int UNIT_W     = 18;
  localparam int NBR_W      = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int NUM_COMP   = 6;
  localparam int NUM_SLOT   = 5;
  localparam int SQ_STEPS   = 3;
  localparam int ROOT_STEPS = 32;
  localparam int DIV_STEPS  = 48;
  localparam int FIN_STEPS  = 3;
  localparam int ITER_W     = 6;
  localparam int COMP_W     = 3;
  localparam int SLOT_W     = 3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_I = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_J = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_K = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INV_I  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INV_J  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INV_K  = 3'd5;

  localparam logic [SZ_W-1:0]  SIZE_RESET = 7'd64;
  localparam logic [INV_W-1:0] INV_RESET  = 32'h0001_0000;

  // Neighbor codes around the center voxel (i, j, k).
  localparam logic [NBR_W-1:0] NB_IMJM = 4'd0;
  localparam logic [NBR_W-1:0] NB_IM   = 4'd1;
  localparam logic [NBR_W-1:0] NB_IMKM = 4'd2;
  localparam logic [NBR_W-1:0] NB_IMKP = 4'd3;
  localparam logic [NBR_W-1:0] NB_IMJP = 4'd4;
  localparam logic [NBR_W-1:0] NB_JMKM = 4'd5;
  localparam logic [NBR_W-1:0] NB_JM   = 4'd6;
  localparam logic [NBR_W-1:0] NB_JMKP = 4'd7;
  localparam logic [NBR_W-1:0] NB_KM   = 4'd8;
  localparam logic [NBR_W-1:0] NB_C    = 4'd9;
  localparam logic [NBR_W-1:0] NB_KP   = 4'd10;
  localparam logic [NBR_W-1:0] NB_JPKM = 4'd11;
  localparam logic [NBR_W-1:0] NB_JP   = 4'd12;
  localparam logic [NBR_W-1:0] NB_IPJM = 4'd13;
  localparam logic [NBR_W-1:0] NB_IPKM = 4'd14;
  localparam logic [NBR_W-1:0] NB_IP   = 4'd15;

  localparam logic signed [1:0] OFS_M = 2'sb11;
  localparam logic signed [1:0] OFS_Z = 2'sb00;
  localparam logic signed [1:0] OFS_P = 2'sb01;

  typedef enum logic [1:0] {AX_I, AX_J, AX_K} axis_t;

  typedef struct packed {
    logic [NBR_W-1:0] a;
    logic [NBR_W-1:0] b;
    axis_t            axis;
  } dq_sel_t;

  typedef struct packed {
    logic signed [1:0] di;
    logic signed [1:0] dj;
    logic signed [1:0] dk;
  } nbr_ofs_t;

  typedef struct packed {
    logic [SZ_W-1:0]  size_i;
    logic [SZ_W-1:0]  size_j;
    logic [SZ_W-1:0]  size_k;
    logic [INV_W-1:0] inv_i;
    logic [INV_W-1:0] inv_j;
    logic [INV_W-1:0] inv_k;
  } cfg_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_ACCEPT, OP_READ, OP_MULT, OP_QUANT, OP_SQUARE,
    OP_ROOT, OP_DIVIDE, OP_UNIT, OP_FINAL, OP_ROUND, OP_EMIT
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CHECK, ST_READ, ST_MULT, ST_QUANT, ST_SQUARE,
    ST_ROOT, ST_DIVIDE, ST_UNIT, ST_FINAL, ST_ROUND, ST_EMIT
  } state_t;

  typedef struct packed {
    op_t               op;
    logic [COMP_W-1:0] comp;
    logic [SLOT_W-1:0] slot;
    logic [ITER_W-1:0] iter;
  } cmd_t;

  typedef struct packed {
    logic due;
    logic out_free;
  } status_t;

  function automatic nbr_ofs_t nbr_ofs(input logic [NBR_W-1:0] n);
    nbr_ofs_t r;
    case (n)
      NB_IMJM: r = '{OFS_M, OFS_M, OFS_Z};
      NB_IM:   r = '{OFS_M, OFS_Z, OFS_Z};
      NB_IMKM: r = '{OFS_M, OFS_Z, OFS_M};
      NB_IMKP: r = '{OFS_M, OFS_Z, OFS_P};
      NB_IMJP: r = '{OFS_M, OFS_P, OFS_Z};
      NB_JMKM: r = '{OFS_Z, OFS_M, OFS_M};
      NB_JM:   r = '{OFS_Z, OFS_M, OFS_Z};
      NB_JMKP: r = '{OFS_Z, OFS_M, OFS_P};
      NB_KM:   r = '{OFS_Z, OFS_Z, OFS_M};
      NB_KP:   r = '{OFS_Z, OFS_Z, OFS_P};
      NB_JPKM: r = '{OFS_Z, OFS_P, OFS_M};
      NB_JP:   r = '{OFS_Z, OFS_P, OFS_Z};
      NB_IPJM: r = '{OFS_P, OFS_M, OFS_Z};
      NB_IPKM: r = '{OFS_P, OFS_Z, OFS_M};
      NB_IP:   r = '{OFS_P, OFS_Z, OFS_Z};
      default: r = '{OFS_Z, OFS_Z, OFS_Z};
    endcase
    return r;
  endfunction

  // Operand pair and axis of each difference quotient. Per component the
  // slots are: numerator, then two minmod pairs.
  function automatic dq_sel_t dq_select(input logic [COMP_W-1:0] comp,
                                        input logic [SLOT_W-1:0] slot);
    logic [4:0] idx;
    dq_sel_t    r;
    idx = 5'(int'(comp) * NUM_SLOT + int'(slot));
    case (idx)
      5'd0:  r = '{NB_IP,   NB_C,    AX_I};
      5'd1:  r = '{NB_JP,   NB_C,    AX_J};
      5'd2:  r = '{NB_C,    NB_JM,   AX_J};
      5'd3:  r = '{NB_KP,   NB_C,    AX_K};
      5'd4:  r = '{NB_C,    NB_KM,   AX_K};
      5'd5:  r = '{NB_JP,   NB_C,    AX_J};
      5'd6:  r = '{NB_IP,   NB_C,    AX_I};
      5'd7:  r = '{NB_C,    NB_IM,   AX_I};
      5'd8:  r = '{NB_KP,   NB_C,    AX_K};
      5'd9:  r = '{NB_C,    NB_KM,   AX_K};
      5'd10: r = '{NB_KP,   NB_C,    AX_K};
      5'd11: r = '{NB_JP,   NB_C,    AX_J};
      5'd12: r = '{NB_C,    NB_JM,   AX_J};
      5'd13: r = '{NB_IP,   NB_C,    AX_I};
      5'd14: r = '{NB_C,    NB_IM,   AX_I};
      5'd15: r = '{NB_C,    NB_IM,   AX_I};
      5'd16: r = '{NB_IMJP, NB_IM,   AX_J};
      5'd17: r = '{NB_IM,   NB_IMJM, AX_J};
      5'd18: r = '{NB_IMKP, NB_IM,   AX_K};
      5'd19: r = '{NB_IM,   NB_IMKM, AX_K};
      5'd20: r = '{NB_C,    NB_JM,   AX_J};
      5'd21: r = '{NB_IPJM, NB_JM,   AX_I};
      5'd22: r = '{NB_JM,   NB_IMJM, AX_I};
      5'd23: r = '{NB_JMKP, NB_JM,   AX_K};
      5'd24: r = '{NB_JM,   NB_JMKM, AX_K};
      5'd25: r = '{NB_C,    NB_KM,   AX_K};
      5'd26: r = '{NB_JPKM, NB_KM,   AX_J};
      5'd27: r = '{NB_KM,   NB_JMKM, AX_J};
      5'd28: r = '{NB_IPKM, NB_KM,   AX_I};
      // The x difference of the k-minus term pairs fjm with fimkm.
      5'd29: r = '{NB_JM,   NB_IMKM, AX_I};
      default: r = '{NB_C,  NB_C,    AX_I};
    endcase
    return r;
  endfunction

endpackage

>>> hdl/tvd_controller.sv
// Sequencer for the TV divergence unit: steps the datapath through reads,
// difference quotients, root, divide and final sum. Depends on tvd_pkg.
`timescale 1ns / 1ps
module tvd_controller (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  tvd_pkg::status_t  status,
  output tvd_pkg::cmd_t     cmd
);

  tvd_pkg::state_t state, state_next;
  logic [tvd_pkg::COMP_W-1:0] comp, comp_next;
  logic [tvd_pkg::SLOT_W-1:0] slot, slot_next;
  logic [tvd_pkg::ITER_W-1:0] iter, iter_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tvd_pkg::ST_IDLE;
      comp  <= '0;
      slot  <= '0;
      iter  <= '0;
    end else begin
      state <= state_next;
      comp  <= comp_next;
      slot  <= slot_next;
      iter  <= iter_next;
    end
  end

  always_comb begin
    state_next = state;
    comp_next  = comp;
    slot_next  = slot;
    iter_next  = iter;
    cmd.op     = tvd_pkg::OP_NONE;
    cmd.comp   = comp;
    cmd.slot   = slot;
    cmd.iter   = iter;
    in_ready   = (state == tvd_pkg::ST_IDLE);
    case (state)
      tvd_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.op     = tvd_pkg::OP_ACCEPT;
          state_next = tvd_pkg::ST_CHECK;
        end
      end
      tvd_pkg::ST_CHECK: begin
        comp_next  = '0;
        slot_next  = '0;
        iter_next  = '0;
        state_next = status.due ? tvd_pkg::ST_READ : tvd_pkg::ST_IDLE;
      end
      tvd_pkg::ST_READ: begin
        cmd.op     = tvd_pkg::OP_READ;
        state_next = tvd_pkg::ST_MULT;
      end
      tvd_pkg::ST_MULT: begin
        cmd.op     = tvd_pkg::OP_MULT;
        state_next = tvd_pkg::ST_QUANT;
      end
      tvd_pkg::ST_QUANT: begin
        cmd.op = tvd_pkg::OP_QUANT;
        if (slot == tvd_pkg::SLOT_W'(tvd_pkg::NUM_SLOT - 1)) begin
          slot_next  = '0;
          iter_next  = '0;
          state_next = tvd_pkg::ST_SQUARE;
        end else begin
          slot_next  = slot + 1'b1;
          state_next = tvd_pkg::ST_READ;
        end
      end
      tvd_pkg::ST_SQUARE: begin
        cmd.op = tvd_pkg::OP_SQUARE;
        if (iter == tvd_pkg::ITER_W'(tvd_pkg::SQ_STEPS - 1)) begin
          iter_next  = '0;
          state_next = tvd_pkg::ST_ROOT;
        end else begin
          iter_next = iter + 1'b1;
        end
      end
      tvd_pkg::ST_ROOT: begin
        cmd.op = tvd_pkg::OP_ROOT;
        if (iter == tvd_pkg::ITER_W'(tvd_pkg::ROOT_STEPS - 1)) begin
          iter_next  = '0;
          state_next = tvd_pkg::ST_DIVIDE;
        end else begin
          iter_next = iter + 1'b1;
        end
      end
      tvd_pkg::ST_DIVIDE: begin
        cmd.op = tvd_pkg::OP_DIVIDE;
        if (iter == tvd_pkg::ITER_W'(tvd_pkg::DIV_STEPS - 1)) begin
          iter_next  = '0;
          state_next = tvd_pkg::ST_UNIT;
        end else begin
          iter_next = iter + 1'b1;
        end
      end
      tvd_pkg::ST_UNIT: begin
        cmd.op = tvd_pkg::OP_UNIT;
        if (comp == tvd_pkg::COMP_W'(tvd_pkg::NUM_COMP - 1)) begin
          comp_next  = '0;
          iter_next  = '0;
          state_next = tvd_pkg::ST_FINAL;
        end else begin
          comp_next  = comp + 1'b1;
          state_next = tvd_pkg::ST_READ;
        end
      end
      tvd_pkg::ST_FINAL: begin
        cmd.op = tvd_pkg::OP_FINAL;
        if (iter == tvd_pkg::ITER_W'(tvd_pkg::FIN_STEPS - 1)) begin
          iter_next  = '0;
          state_next = tvd_pkg::ST_ROUND;
        end else begin
          iter_next = iter + 1'b1;
        end
      end
      tvd_pkg::ST_ROUND: begin
        cmd.op     = tvd_pkg::OP_ROUND;
        state_next = tvd_pkg::ST_EMIT;
      end
      tvd_pkg::ST_EMIT: begin
        if (status.out_free) begin
          cmd.op     = tvd_pkg::OP_EMIT;
          state_next = tvd_pkg::ST_IDLE;
        end
      end
      default: state_next = tvd_pkg::ST_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_accept_to_check: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == tvd_pkg::ST_CHECK))
    else $error("accepted transfer did not lead to the check state");

  a_counters_range: assert property (@(posedge clk) disable iff (rst)
    (slot < tvd_pkg::SLOT_W'(tvd_pkg::NUM_SLOT)) &&
    (comp < tvd_pkg::COMP_W'(tvd_pkg::NUM_COMP)))
    else $error("slot or component counter out of range");

  a_emit_needs_room: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == tvd_pkg::OP_EMIT) |-> status.out_free)
    else $error("result issued while output register is full");

  a_round_then_emit: assert property (@(posedge clk) disable iff (rst)
    (state == tvd_pkg::ST_ROUND) |=> (state == tvd_pkg::ST_EMIT))
    else $error("rounding not followed by emit");
`endif

endmodule

>>> hdl/tvd_datapath.sv
// Datapath of the TV divergence unit: window memory, position tracking,
// difference quotients, square root, divider, final sum and output register.
// Depends on tvd_pkg; driven by tvd_controller.
`timescale 1ns / 1ps
module tvd_datapath #(
  parameter int MAX_DIM_I = 64,
  parameter int MAX_DIM_J = 64,
  parameter int MAX_DIM_K = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  tvd_pkg::cfg_t              cfg,
  input  tvd_pkg::cmd_t              cmd,
  output tvd_pkg::status_t           status,
  input  logic                       action,
  input  logic [tvd_pkg::DATA_W-1:0] sample,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [tvd_pkg::DATA_W-1:0] divergence,
  output logic                       last
);

  localparam int WIN_DEPTH = 2 * MAX_DIM_J * MAX_DIM_K + MAX_DIM_K + 1;
  localparam int AW  = $clog2(WIN_DEPTH);
  localparam int OW  = AW + 2;
  localparam int IW  = $clog2(MAX_DIM_I + 1);
  localparam int JW  = $clog2(MAX_DIM_J + 1);
  localparam int KW  = $clog2(MAX_DIM_K + 1);
  localparam int PLW = $clog2(MAX_DIM_J * MAX_DIM_K + 1);
  localparam int PW  = $clog2(MAX_DIM_I * MAX_DIM_J * MAX_DIM_K + 1);
  localparam logic signed [OW-1:0] WIN_S = OW'(WIN_DEPTH);
  localparam logic [AW-1:0] WIN_LAST = AW'(WIN_DEPTH - 1);

  function automatic logic signed [31:0] minmod(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
    logic signed [31:0] r;
    if (a < 0 && b < 0) r = (a >= b) ? a : b;
    else if (a > 0 && b > 0) r = (a < b) ? a : b;
    else r = '0;
    return r;
  endfunction

  // Clamped sizes and derived counts.
  logic [IW-1:0]  ni;
  logic [JW-1:0]  nj;
  logic [KW-1:0]  nk;
  logic [PLW-1:0] plane;
  logic [PW-1:0]  total;

  always_comb begin
    if (cfg.size_i == '0) ni = IW'(1);
    else if (int'(cfg.size_i) > MAX_DIM_I) ni = IW'(MAX_DIM_I);
    else ni = IW'(cfg.size_i);
    if (cfg.size_j == '0) nj = JW'(1);
    else if (int'(cfg.size_j) > MAX_DIM_J) nj = JW'(MAX_DIM_J);
    else nj = JW'(cfg.size_j);
    if (cfg.size_k == '0) nk = KW'(1);
    else if (int'(cfg.size_k) > MAX_DIM_K) nk = KW'(MAX_DIM_K);
    else nk = KW'(cfg.size_k);
    plane = PLW'(PLW'(nj) * PLW'(nk));
    total = PW'(PW'(ni) * PW'(plane));
  end

  // Positions in the volume and their window addresses.
  logic [PW-1:0] ipos, opos;
  logic [AW-1:0] waddr, oaddr;
  logic [IW-1:0] pos_i;
  logic [JW-1:0] pos_j;
  logic [KW-1:0] pos_k;

  logic          clr, take, last_flag;
  logic [PW-1:0] ipos_base;
  logic [AW-1:0] waddr_base;

  always_comb begin
    clr        = (opos >= total);
    ipos_base  = clr ? '0 : ipos;
    waddr_base = clr ? '0 : waddr;
    take       = !action && (ipos_base < total);
    last_flag  = ((opos + 1'b1) == total);
    status.due = (((PW+1)'(opos) + (PW+1)'(plane)) < (PW+1)'(ipos)) || (ipos >= total);
    status.out_free = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ipos  <= '0;
      opos  <= '0;
      waddr <= '0;
      oaddr <= '0;
      pos_i <= '0;
      pos_j <= '0;
      pos_k <= '0;
    end else if (cmd.op == tvd_pkg::OP_ACCEPT) begin
      if (take) begin
        ipos  <= ipos_base + 1'b1;
        waddr <= (waddr_base == WIN_LAST) ? '0 : waddr_base + 1'b1;
      end else begin
        ipos  <= ipos_base;
        waddr <= waddr_base;
      end
      if (clr) begin
        opos  <= '0;
        oaddr <= '0;
        pos_i <= '0;
        pos_j <= '0;
        pos_k <= '0;
      end
    end else if (cmd.op == tvd_pkg::OP_EMIT) begin
      if (last_flag) begin
        ipos  <= '0;
        opos  <= '0;
        waddr <= '0;
        oaddr <= '0;
        pos_i <= '0;
        pos_j <= '0;
        pos_k <= '0;
      end else begin
        opos  <= opos + 1'b1;
        oaddr <= (oaddr == WIN_LAST) ? '0 : oaddr + 1'b1;
        if ((KW+1)'(pos_k) + 1'b1 >= (KW+1)'(nk)) begin
          pos_k <= '0;
          if ((JW+1)'(pos_j) + 1'b1 >= (JW+1)'(nj)) begin
            pos_j <= '0;
            pos_i <= pos_i + 1'b1;
          end else begin
            pos_j <= pos_j + 1'b1;
          end
        end else begin
          pos_k <= pos_k + 1'b1;
        end
      end
    end
  end

  // Neighbor addresses; indexes clamp at the volume border.
  tvd_pkg::dq_sel_t sel;
  tvd_pkg::nbr_ofs_t ofs [2];
  logic [tvd_pkg::NBR_W-1:0] nbr [2];
  logic signed [OW-1:0] d_i [2];
  logic signed [OW-1:0] d_j [2];
  logic signed [OW-1:0] d_k [2];
  logic signed [OW-1:0] sum_a [2];
  logic [AW-1:0] raddr [2];
  logic i_lo, i_hi, j_lo, j_hi, k_lo, k_hi;

  always_comb begin
    sel  = tvd_pkg::dq_select(cmd.comp, cmd.slot);
    nbr[0] = sel.a;
    nbr[1] = sel.b;
    i_lo = (pos_i != '0);
    j_lo = (pos_j != '0);
    k_lo = (pos_k != '0);
    i_hi = ((IW+1)'(pos_i) + 1'b1) < (IW+1)'(ni);
    j_hi = ((JW+1)'(pos_j) + 1'b1) < (JW+1)'(nj);
    k_hi = ((KW+1)'(pos_k) + 1'b1) < (KW+1)'(nk);
    for (int p = 0; p < 2; p++) begin
      ofs[p] = tvd_pkg::nbr_ofs(nbr[p]);
      if (ofs[p].di == tvd_pkg::OFS_M && i_lo) d_i[p] = -$signed(OW'(plane));
      else if (ofs[p].di == tvd_pkg::OFS_P && i_hi) d_i[p] = $signed(OW'(plane));
      else d_i[p] = '0;
      if (ofs[p].dj == tvd_pkg::OFS_M && j_lo) d_j[p] = -$signed(OW'(nk));
      else if (ofs[p].dj == tvd_pkg::OFS_P && j_hi) d_j[p] = $signed(OW'(nk));
      else d_j[p] = '0;
      if (ofs[p].dk == tvd_pkg::OFS_M && k_lo) d_k[p] = -$signed(OW'(1));
      else if (ofs[p].dk == tvd_pkg::OFS_P && k_hi) d_k[p] = $signed(OW'(1));
      else d_k[p] = '0;
      sum_a[p] = $signed(OW'(oaddr)) + d_i[p] + d_j[p] + d_k[p];
      if (sum_a[p] < 0) raddr[p] = AW'(sum_a[p] + WIN_S);
      else if (sum_a[p] >= WIN_S) raddr[p] = AW'(sum_a[p] - WIN_S);
      else raddr[p] = AW'(sum_a[p]);
    end
  end

  // Window memory: one write port, two registered read ports.
  logic [tvd_pkg::DATA_W-1:0] mem [WIN_DEPTH];
  logic [tvd_pkg::DATA_W-1:0] rd_a, rd_b;

  always_ff @(posedge clk) begin
    if (cmd.op == tvd_pkg::OP_ACCEPT && take) begin
      mem[waddr_base] <= sample;
    end
    rd_a <= mem[raddr[0]];
    rd_b <= mem[raddr[1]];
  end

  // Difference quotient, then the shared root and divide units.
  logic [tvd_pkg::INV_W-1:0] inv_sel;
  logic signed [32:0] diff_ab;
  logic [32:0] diff_mag;
  logic [64:0] prod;
  logic        prod_neg;
  logic [47:0] q48;
  logic signed [31:0] dq_val;
  logic signed [31:0] dqs [tvd_pkg::NUM_SLOT];
  logic signed [31:0] t1, t2, sq_src;
  logic [31:0] sq_mag;
  logic [63:0] rad;
  logic [35:0] rrem, r_in, r_trial;
  logic [31:0] root;
  logic [47:0] dividend;
  logic [31:0] drem;
  logic [32:0] d_in;
  logic        num_neg;
  logic signed [tvd_pkg::UNIT_W-1:0] uq;
  logic signed [tvd_pkg::UNIT_W-1:0] units [tvd_pkg::NUM_COMP];

  always_comb begin
    case (sel.axis)
      tvd_pkg::AX_I: inv_sel = cfg.inv_i;
      tvd_pkg::AX_J: inv_sel = cfg.inv_j;
      tvd_pkg::AX_K: inv_sel = cfg.inv_k;
      default:       inv_sel = cfg.inv_i;
    endcase
    diff_ab  = $signed({rd_a[31], rd_a}) - $signed({rd_b[31], rd_b});
    diff_mag = diff_ab[32] ? 33'(-diff_ab) : 33'(diff_ab);
    q48 = prod[63:16];
    if (prod_neg) begin
      dq_val = -$signed((q48 > 48'h8000_0000) ? 32'h8000_0000 : q48[31:0]);
    end else begin
      dq_val = $signed((q48 > 48'h7FFF_FFFF) ? 32'h7FFF_FFFF : q48[31:0]);
    end
    t1 = minmod(dqs[1], dqs[2]);
    t2 = minmod(dqs[3], dqs[4]);
    case (cmd.iter[1:0])
      2'd0:    sq_src = dqs[0];
      2'd1:    sq_src = t1;
      default: sq_src = t2;
    endcase
    sq_mag  = sq_src[31] ? 32'(-sq_src) : 32'(sq_src);
    r_in    = {rrem[33:0], rad[63:62]};
    r_trial = {2'b00, root, 2'b01};
    d_in    = {drem, dividend[47]};
    if (root == '0) uq = '0;
    else if (num_neg) uq = -$signed({1'b0, dividend[16:0]});
    else uq = $signed({1'b0, dividend[16:0]});
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      tvd_pkg::OP_MULT: begin
        prod     <= 65'(diff_mag) * 65'(inv_sel);
        prod_neg <= diff_ab[32];
      end
      tvd_pkg::OP_QUANT: dqs[cmd.slot] <= dq_val;
      tvd_pkg::OP_SQUARE: begin
        if (cmd.iter == '0) begin
          rad      <= 64'(sq_mag) * 64'(sq_mag);
          rrem     <= '0;
          root     <= '0;
          drem     <= '0;
          num_neg  <= dqs[0][31];
          dividend <= {(dqs[0][31] ? 32'(-dqs[0]) : 32'(dqs[0])), 16'h0000};
        end else begin
          rad <= rad + 64'(sq_mag) * 64'(sq_mag);
        end
      end
      tvd_pkg::OP_ROOT: begin
        // One result bit per step of the digit-by-digit square root.
        rad <= {rad[61:0], 2'b00};
        if (r_in >= r_trial) begin
          rrem <= r_in - r_trial;
          root <= {root[30:0], 1'b1};
        end else begin
          rrem <= r_in;
          root <= {root[30:0], 1'b0};
        end
      end
      tvd_pkg::OP_DIVIDE: begin
        if (d_in >= {1'b0, root}) begin
          drem     <= 32'(d_in - {1'b0, root});
          dividend <= {dividend[46:0], 1'b1};
        end else begin
          drem     <= d_in[31:0];
          dividend <= {dividend[46:0], 1'b0};
        end
      end
      tvd_pkg::OP_UNIT: units[cmd.comp] <= uq;
      default: ;
    endcase
  end

  // Final weighted sum of unit differences, rounding and saturation.
  logic signed [18:0] udiff;
  logic [tvd_pkg::INV_W-1:0] inv_fin;
  logic signed [51:0] prodf;
  logic signed [53:0] acc, adj, shr;
  logic [tvd_pkg::DATA_W-1:0] res, res_val;

  always_comb begin
    case (cmd.iter[1:0])
      2'd0: begin
        udiff   = 19'(units[0]) - 19'(units[3]);
        inv_fin = cfg.inv_i;
      end
      2'd1: begin
        udiff   = 19'(units[1]) - 19'(units[4]);
        inv_fin = cfg.inv_j;
      end
      default: begin
        udiff   = 19'(units[2]) - 19'(units[5]);
        inv_fin = cfg.inv_k;
      end
    endcase
    prodf = 52'(udiff) * 52'($signed({1'b0, inv_fin}));
    adj   = acc + (acc < 0 ? 54'sd65535 : 54'sd0);
    shr   = adj >>> 16;
    if (shr > 54'sd2147483647) res_val = 32'h7FFF_FFFF;
    else if (shr < -54'sd2147483648) res_val = 32'h8000_0000;
    else res_val = shr[31:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.op == tvd_pkg::OP_FINAL) begin
      acc <= ((cmd.iter == '0) ? 54'sd0 : acc) + 54'(prodf);
    end
    if (cmd.op == tvd_pkg::OP_ROUND) begin
      res <= res_val;
    end
  end

  // Output register decouples the result from the next item's work.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == tvd_pkg::OP_EMIT) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == tvd_pkg::OP_EMIT) begin
      divergence <= res;
      last       <= last_flag;
    end
  end

endmodule

>>> hdl/tv_unit_gradient_divergence_3d.sv
// Top level of the 3D total-variation divergence unit: configuration
// registers, stream ports, controller and datapath. Depends on tvd_pkg.
// An item that completes a voxel runs six unit components, each needing a
// 32-step square root and a 48-step divider on one shared unit; an item
// that completes nothing goes back to idle after the check. s_tready stays
// low until an item is finished, so a new sample waits for the last one.
// Reset (rst, synchronous) clears positions, control and the config
// registers; the window memory is left as is and needs no clearing pass.
`timescale 1ns / 1ps
module tv_unit_gradient_divergence_3d #(
  parameter int MAX_DIM_I = 64,
  parameter int MAX_DIM_J = 64,
  parameter int MAX_DIM_K = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [31:0]                   s_tdata,   // sample[31:0]
  input  logic                          s_tuser,   // action[0]
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [31:0]                   m_tdata,   // divergence[31:0]
  output logic                          m_tlast,
  input  logic                          cfg_we,
  input  logic [tvd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data
);

  tvd_pkg::cfg_t    cfg;
  tvd_pkg::cmd_t    cmd;
  tvd_pkg::status_t status;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.size_i <= tvd_pkg::SIZE_RESET;
      cfg.size_j <= tvd_pkg::SIZE_RESET;
      cfg.size_k <= tvd_pkg::SIZE_RESET;
      cfg.inv_i  <= tvd_pkg::INV_RESET;
      cfg.inv_j  <= tvd_pkg::INV_RESET;
      cfg.inv_k  <= tvd_pkg::INV_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        tvd_pkg::REG_SIZE_I: cfg.size_i <= cfg_data[tvd_pkg::SZ_W-1:0];
        tvd_pkg::REG_SIZE_J: cfg.size_j <= cfg_data[tvd_pkg::SZ_W-1:0];
        tvd_pkg::REG_SIZE_K: cfg.size_k <= cfg_data[tvd_pkg::SZ_W-1:0];
        tvd_pkg::REG_INV_I:  cfg.inv_i  <= cfg_data;
        tvd_pkg::REG_INV_J:  cfg.inv_j  <= cfg_data;
        tvd_pkg::REG_INV_K:  cfg.inv_k  <= cfg_data;
        default: ;
      endcase
    end
  end

  tvd_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  tvd_datapath #(
    .MAX_DIM_I (MAX_DIM_I),
    .MAX_DIM_J (MAX_DIM_J),
    .MAX_DIM_K (MAX_DIM_K)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .cmd        (cmd),
    .status     (status),
    .action     (s_tuser),
    .sample     (s_tdata),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .divergence (m_tdata),
    .last       (m_tlast)
  );

endmodule
